FILE: design/sortmrg_pkg.sv
`default_nettype none

package sortmrg_pkg;

   localparam int CAPACITY = 32;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;

   localparam logic [1:0] OP_INS_A = 2'd0;
   localparam logic [1:0] OP_INS_B = 2'd1;
   localparam logic [1:0] OP_MERGE = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_MERGE = 2'd2;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_out;
      logic                     last;
      logic                     empty_res;
      logic [1:0]               status;
   } rsp_type;

endpackage

`default_nettype wire

FILE: design/sortmrg_ram.sv
`default_nettype none

module sortmrg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: design/sorted_insert_and_merge.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  sortmrg_pkg::req_type (op, value)
// rsp_      out        rsp_valid/rsp_stall  sortmrg_pkg::rsp_type (value_out, last,
//                                           empty_res, status)
//
// Insert: larger entries shift up one slot, then the value is written; a full store
// answers ST_FULL. Merge: each result uses the one shared comparator and the
// registered read ports of the two store RAMs; an empty merge sets empty_res. Reset
// clears the state, counts and output valid; store contents are not cleared.
// A stalled result holds in the output register and the sequencer waits on it.

module sorted_insert_and_merge (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire sortmrg_pkg::req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output sortmrg_pkg::rsp_type      rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_RESP,
      S_MRG_RD,
      S_MRG_CMP
   } state_type;

   localparam int AW = sortmrg_pkg::ADDR_W;
   localparam int CW = sortmrg_pkg::CNT_W;
   localparam int DW = sortmrg_pkg::DATA_W;

   state_type state_ff, state_in;
   logic [CW-1:0] count_a_ff, count_a_in;
   logic [CW-1:0] count_b_ff, count_b_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] ia_ff, ia_in;
   logic [CW-1:0] ib_ff, ib_in;
   logic          sel_b_ff, sel_b_in;
   logic [DW-1:0] value_ff, value_in;
   logic [1:0]    status_ff, status_in;
   logic          empty_ff, empty_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sortmrg_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          wr_en_a, wr_en_b, wr_en;
   logic [AW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic [DW-1:0] rd_a, rd_b, rd_sel;
   logic [CW-1:0] idx_m1;

   logic signed [DW-1:0] cmp_x, cmp_y;
   logic                 cmp_lt;

   logic          slot_free;
   logic [CW-1:0] cnt_req;
   logic          a_avail, b_avail, take_a, last_elem;
   logic [CW:0]   done_next, total;

   sortmrg_ram #(.WIDTH(DW), .DEPTH(sortmrg_pkg::CAPACITY)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (rd_a)
   );

   sortmrg_ram #(.WIDTH(DW), .DEPTH(sortmrg_pkg::CAPACITY)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (rd_b)
   );

   assign idx_m1  = idx_ff - CW'(1);
   assign rd_sel  = sel_b_ff ? rd_b : rd_a;
   assign wr_en_a = wr_en && !sel_b_ff;
   assign wr_en_b = wr_en && sel_b_ff;

   always_comb begin
      if (state_ff == S_MRG_RD || state_ff == S_MRG_CMP) begin
         rd_addr_a = ia_ff[AW-1:0];
         rd_addr_b = ib_ff[AW-1:0];
      end else begin
         rd_addr_a = idx_m1[AW-1:0];
         rd_addr_b = idx_m1[AW-1:0];
      end
   end

   always_comb begin
      if (state_ff == S_MRG_CMP) begin
         cmp_x = rd_a;
         cmp_y = rd_b;
      end else begin
         cmp_x = value_ff;
         cmp_y = rd_sel;
      end
   end
   assign cmp_lt = cmp_x < cmp_y;

   assign a_avail   = ia_ff < count_a_ff;
   assign b_avail   = ib_ff < count_b_ff;
   assign take_a    = a_avail && (!b_avail || cmp_lt);
   assign done_next = {1'b0, ia_ff} + {1'b0, ib_ff} + (CW+1)'(1);
   assign total     = {1'b0, count_a_ff} + {1'b0, count_b_ff};
   assign last_elem = done_next == total;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign cnt_req   = (req_data.op == sortmrg_pkg::OP_INS_B) ? count_b_ff : count_a_ff;

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      idx_in       = idx_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      sel_b_in     = sel_b_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      empty_in     = empty_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = value_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_data.op) inside
                  sortmrg_pkg::OP_INS_A, sortmrg_pkg::OP_INS_B: begin
                     sel_b_in = req_data.op == sortmrg_pkg::OP_INS_B;
                     value_in = req_data.value;
                     empty_in = 1'b0;
                     if (cnt_req == CW'(sortmrg_pkg::CAPACITY)) begin
                        status_in = sortmrg_pkg::ST_FULL;
                        state_in  = S_RESP;
                     end else begin
                        idx_in   = cnt_req;
                        state_in = S_INS_RD;
                     end
                  end
                  sortmrg_pkg::OP_MERGE: begin
                     ia_in = '0;
                     ib_in = '0;
                     if (count_a_ff == '0 && count_b_ff == '0) begin
                        status_in = sortmrg_pkg::ST_OK;
                        empty_in  = 1'b1;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_MRG_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS_RD: begin
            if (idx_ff == '0) begin
               wr_en     = 1'b1;
               status_in = sortmrg_pkg::ST_OK;
               state_in  = S_RESP;
               if (sel_b_ff) count_b_in = count_b_ff + CW'(1);
               else          count_a_in = count_a_ff + CW'(1);
            end else begin
               state_in = S_INS_CMP;
            end
         end
         S_INS_CMP: begin
            wr_en = 1'b1;
            if (cmp_lt) begin
               wr_data  = rd_sel;
               idx_in   = idx_m1;
               state_in = S_INS_RD;
            end else begin
               status_in = sortmrg_pkg::ST_OK;
               state_in  = S_RESP;
               if (sel_b_ff) count_b_in = count_b_ff + CW'(1);
               else          count_a_in = count_a_ff + CW'(1);
            end
         end
         S_RESP: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.value_out = '0;
               rsp_data_in.last      = 1'b1;
               rsp_data_in.empty_res = empty_ff;
               rsp_data_in.status    = status_ff;
               state_in              = S_IDLE;
            end
         end
         S_MRG_RD: begin
            state_in = S_MRG_CMP;
         end
         S_MRG_CMP: begin
            if (slot_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.value_out = take_a ? rd_a : rd_b;
               rsp_data_in.last      = last_elem;
               rsp_data_in.empty_res = 1'b0;
               rsp_data_in.status    = sortmrg_pkg::ST_MERGE;
               if (take_a) ia_in = ia_ff + CW'(1);
               else        ib_in = ib_ff + CW'(1);
               state_in = last_elem ? S_IDLE : S_MRG_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      ia_ff       <= ia_in;
      ib_ff       <= ib_in;
      sel_b_ff    <= sel_b_in;
      value_ff    <= value_in;
      status_ff   <= status_in;
      empty_ff    <= empty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
